### rtl/core/sdp_pkg.sv
package sdp_pkg;

   localparam int DEPTH_W = 32;
   localparam int CENTRE_W = 15;
   localparam int SCALE_W = 25;
   localparam int SCALE_Q_W = 24;
   localparam int BRIGHT_W = 8;
   localparam int SCREEN_W = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [DEPTH_W-1:0] NEAR_RESET = 32'd65536;
   localparam logic [DEPTH_W-1:0] FAR_RESET = 32'd6553600;
   localparam logic [DEPTH_W-1:0] STEP_RESET = 32'd65536;
   localparam logic [CENTRE_W-1:0] CENTRE_X_RESET = 15'd400;
   localparam logic [CENTRE_W-1:0] CENTRE_Y_RESET = 15'd300;

   localparam logic [CSR_IDX_W-1:0] CSR_NEAR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_Y = 3'd4;
   // An index with no register behind it; writes to it are dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   // Depths at or below one unit give the full size factor.
   localparam logic [DEPTH_W-1:0] DEPTH_ONE = 32'd65536;
   localparam logic [SCALE_W-1:0] SCALE_ONE = 25'd16777216;
   localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = 8'd255;

   localparam logic [1:0] BMODE_DIV = 2'd0;
   localparam logic [1:0] BMODE_ZERO = 2'd1;
   localparam logic [1:0] BMODE_FULL = 2'd2;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic               wrapped;
      logic               visible;
      logic               unit_depth;
      logic [1:0]         bmode;
      logic [DEPTH_W-1:0] num;
   } depth_type;

endpackage

### rtl/core/sdp_ifs.sv
interface sdp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] world_x;
   logic signed [31:0] world_y;
   logic [31:0]        depth_in;
   modport source (output valid, world_x, world_y, depth_in, input ready);
   modport sink (input valid, world_x, world_y, depth_in, output ready);
endinterface

interface sdp_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        depth_out;
   logic               wrapped;
   logic               visible;
   logic signed [15:0] screen_x;
   logic signed [15:0] screen_y;
   logic [24:0]        scale;
   logic [7:0]         brightness;
   modport source (output valid, depth_out, wrapped, visible, screen_x, screen_y, scale,
                   brightness, input ready);
   modport sink (input valid, depth_out, wrapped, visible, screen_x, screen_y, scale,
                 brightness, output ready);
endinterface

interface sdp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/sdp_delay.sv
module sdp_delay #(
   parameter int W = 8,
   parameter int N = 2
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] tap_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < N; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[N-1];
endmodule

### rtl/core/sdp_front.sv
module sdp_front (
   input  logic                clock,
   input  logic                en,
   input  logic [31:0]         depth_in,
   input  logic [31:0]         near_depth,
   input  logic [31:0]         far_depth,
   input  logic [31:0]         depth_step,
   output sdp_pkg::depth_type  result
);
   logic signed [32:0] s_ff, s_in;
   logic [31:0]        d_ff, d_in;
   logic               wrap_ff, wrap_in;
   sdp_pkg::depth_type res_ff, res_in;

   logic signed [33:0] near_s, fn_s, s_x, den_s;
   logic signed [34:0] dw, dsel;
   logic signed [32:0] num_s;

   assign s_in = $signed({1'b0, depth_in}) - $signed({1'b0, depth_step});

   always_comb begin
      near_s = $signed({2'b0, near_depth});
      fn_s = $signed({2'b0, far_depth}) - near_s;
      s_x = {s_ff[32], s_ff};
      wrap_in = s_x < near_s;
      dw = {fn_s[33], fn_s} + {{2{s_ff[32]}}, s_ff};
      dsel = wrap_in ? dw : {{2{s_ff[32]}}, s_ff};
      // A wrapped depth can only go negative when the step is too large.
      d_in = dsel[34] ? '0 : dsel[31:0];
   end

   always_comb begin
      den_s = fn_s;
      num_s = $signed({1'b0, far_depth}) - $signed({1'b0, d_ff});
      res_in.depth = d_ff;
      res_in.wrapped = wrap_ff;
      res_in.visible = d_ff > near_depth;
      res_in.unit_depth = d_ff <= sdp_pkg::DEPTH_ONE;
      res_in.num = num_s[31:0];
      priority if (den_s <= 34'sd0) begin
         res_in.bmode = (d_ff <= near_depth) ? sdp_pkg::BMODE_FULL : sdp_pkg::BMODE_ZERO;
      end else if (num_s <= 33'sd0) begin
         res_in.bmode = sdp_pkg::BMODE_ZERO;
      end else if ({num_s[32], num_s} >= den_s) begin
         res_in.bmode = sdp_pkg::BMODE_FULL;
      end else begin
         res_in.bmode = sdp_pkg::BMODE_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= s_in;
         d_ff <= d_in;
         wrap_ff <= wrap_in;
         res_ff <= res_in;
      end
   end

   assign result = res_ff;
endmodule

### rtl/core/sdp_div.sv
module sdp_div #(
   parameter int DW = 32,
   parameter int QW = 8
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] rem_init,
   input  logic [QW-1:0] low_init,
   input  logic [DW-1:0] divisor,
   output logic [QW-1:0] quotient
);
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [DW-1:0] dvs_ff [QW];

   // One quotient bit per stage; the partial remainder stays below the divisor.
   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] rem_p, dvs_p, rem_in;
      logic [QW-1:0] low_p, quo_p, low_in, quo_in;
      logic [DW:0]   trial, diff;
      logic          ge;

      if (k == 0) begin : g_first
         assign rem_p = rem_init;
         assign low_p = low_init;
         assign quo_p = '0;
         assign dvs_p = divisor;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign low_p = low_ff[k-1];
         assign quo_p = quo_ff[k-1];
         assign dvs_p = dvs_ff[k-1];
      end

      always_comb begin
         trial = {rem_p, low_p[QW-1]};
         diff = trial - {1'b0, dvs_p};
         ge = trial >= {1'b0, dvs_p};
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         low_in = low_p << 1;
         quo_in = (quo_p << 1) | QW'(ge);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= low_in;
            quo_ff[k] <= quo_in;
            dvs_ff[k] <= dvs_p;
         end
      end
   end

   assign quotient = quo_ff[QW-1];
endmodule

### rtl/core/sdp_proj.sv
module sdp_proj (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] world,
   input  logic [24:0]        scale,
   input  logic [14:0]        centre,
   output logic signed [15:0] screen
);
   logic signed [57:0] prod_ff, prod_in;
   logic signed [15:0] scr_ff, scr_in;
   logic signed [58:0] sum;
   logic signed [26:0] whole;

   assign prod_in = world * $signed({1'b0, scale});

   always_comb begin
      sum = $signed({prod_ff[57], prod_ff}) + $signed({12'b0, centre, 32'b0});
      // An arithmetic shift floors toward minus infinity.
      whole = sum[58:32];
      priority if (whole > 27'sd32767) begin
         scr_in = 16'sh7FFF;
      end else if (whole < -27'sd32768) begin
         scr_in = 16'sh8000;
      end else begin
         scr_in = whole[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         scr_ff <= scr_in;
      end
   end

   assign screen = scr_ff;
endmodule

### rtl/core/star_depth_step_project.sv
// Starfield projection, one star per transaction on req_bus, one result per
// transaction on rsp_bus, both valid/ready channels.
// Each star is moved nearer by the depth step, wrapped to the far plane when it
// passes the near plane, then projected with the reciprocal of its new depth.
// csr_bus writes the near, far, step and centre registers; it is always ready
// and should be used only while no transaction is in flight.
// The pipeline has 29 register stages: three of depth update, a 24-stage
// reciprocal divider (one quotient bit per stage) and two of multiply and
// saturate. A new star is accepted every cycle while the output is not stalled.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// req_bus.ready drops; nothing is lost or repeated.
// Reset clears the pipeline's valid bits and sets the registers to their
// default values (near 1.0, far 100.0, step 1.0, centre 400 by 300).
module star_depth_step_project (
   input logic      clock,
   input logic      reset,
   sdp_req_if.sink  req_bus,
   sdp_rsp_if.source rsp_bus,
   sdp_csr_if.sink  csr_bus
);
   localparam int FRONT_N = 3;
   localparam int SDIV_N = sdp_pkg::SCALE_Q_W;
   localparam int BDIV_N = sdp_pkg::BRIGHT_W;
   localparam int PROJ_N = 2;
   localparam int LAT = FRONT_N + SDIV_N + PROJ_N;

   logic [31:0] near_ff, far_ff, step_ff;
   logic [14:0] cx_ff, cy_ff;
   logic [LAT-1:0] valid_ff;
   logic adv;

   assign adv = !valid_ff[LAT-1] || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= sdp_pkg::NEAR_RESET;
         far_ff <= sdp_pkg::FAR_RESET;
         step_ff <= sdp_pkg::STEP_RESET;
         cx_ff <= sdp_pkg::CENTRE_X_RESET;
         cy_ff <= sdp_pkg::CENTRE_Y_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            sdp_pkg::CSR_NEAR: near_ff <= csr_bus.data;
            sdp_pkg::CSR_FAR: far_ff <= csr_bus.data;
            sdp_pkg::CSR_STEP: step_ff <= csr_bus.data;
            sdp_pkg::CSR_CENTRE_X: cx_ff <= csr_bus.data[14:0];
            sdp_pkg::CSR_CENTRE_Y: cy_ff <= csr_bus.data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT-2:0], req_bus.valid};
      end
   end

   sdp_pkg::depth_type front;

   sdp_front u_front (
      .clock(clock), .en(adv), .depth_in(req_bus.depth_in),
      .near_depth(near_ff), .far_depth(far_ff), .depth_step(step_ff),
      .result(front)
   );

   // Reciprocal: 2^40 / depth, as a 24-bit quotient.
   logic [SDIV_N-1:0] scale_q;
   logic              unit_d;
   logic [24:0]       scale_val;

   sdp_div #(.DW(32), .QW(SDIV_N)) u_sdiv (
      .clock(clock), .en(adv), .rem_init(32'h0001_0000), .low_init('0),
      .divisor(front.depth), .quotient(scale_q)
   );

   sdp_delay #(.W(1), .N(SDIV_N)) u_unit_dly (
      .clock(clock), .en(adv), .din(front.unit_depth), .dout(unit_d)
   );

   assign scale_val = unit_d ? sdp_pkg::SCALE_ONE : {1'b0, scale_q};

   // Brightness: 255 * num / (far - near), with num already known to be in range.
   logic [39:0] bprod;
   logic [31:0] den;
   logic [7:0]  bright_q, bright_val, bright_out;
   logic [1:0]  bmode_d;

   assign bprod = {front.num, 8'b0} - {8'b0, front.num};
   assign den = far_ff - near_ff;

   sdp_div #(.DW(32), .QW(BDIV_N)) u_bdiv (
      .clock(clock), .en(adv), .rem_init(bprod[39:8]), .low_init(bprod[7:0]),
      .divisor(den), .quotient(bright_q)
   );

   sdp_delay #(.W(2), .N(BDIV_N)) u_bmode_dly (
      .clock(clock), .en(adv), .din(front.bmode), .dout(bmode_d)
   );

   always_comb begin
      unique case (bmode_d)
         sdp_pkg::BMODE_ZERO: bright_val = '0;
         sdp_pkg::BMODE_FULL: bright_val = sdp_pkg::BRIGHT_FULL;
         default: bright_val = bright_q;
      endcase
   end

   sdp_delay #(.W(8), .N(SDIV_N - BDIV_N + PROJ_N)) u_bright_dly (
      .clock(clock), .en(adv), .din(bright_val), .dout(bright_out)
   );

   // Depth and flags ride alongside the divider and projection stages.
   logic [33:0] dflags_out;

   sdp_delay #(.W(34), .N(SDIV_N + PROJ_N)) u_depth_dly (
      .clock(clock), .en(adv), .din({front.depth, front.wrapped, front.visible}),
      .dout(dflags_out)
   );

   logic [24:0] scale_out;

   sdp_delay #(.W(25), .N(PROJ_N)) u_scale_dly (
      .clock(clock), .en(adv), .din(scale_val), .dout(scale_out)
   );

   logic [63:0] world_d;

   sdp_delay #(.W(64), .N(FRONT_N + SDIV_N)) u_world_dly (
      .clock(clock), .en(adv), .din({req_bus.world_x, req_bus.world_y}), .dout(world_d)
   );

   logic signed [15:0] sx, sy;

   sdp_proj u_proj_x (
      .clock(clock), .en(adv), .world($signed(world_d[63:32])), .scale(scale_val),
      .centre(cx_ff), .screen(sx)
   );

   sdp_proj u_proj_y (
      .clock(clock), .en(adv), .world($signed(world_d[31:0])), .scale(scale_val),
      .centre(cy_ff), .screen(sy)
   );

   assign rsp_bus.valid = valid_ff[LAT-1];
   assign rsp_bus.depth_out = dflags_out[33:2];
   assign rsp_bus.wrapped = dflags_out[1];
   assign rsp_bus.visible = dflags_out[0];
   assign rsp_bus.screen_x = sx;
   assign rsp_bus.screen_y = sy;
   assign rsp_bus.scale = scale_out;
   assign rsp_bus.brightness = bright_out;
endmodule
